// ===== rtl/kbd_tx_pkg.sv =====
// Shared types and constants of the keyboard serial key transmitter.
`default_nettype none
package kbd_tx_pkg;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [6:0] WARN_CODE = 7'h78;
	localparam logic [6:0] KEY_CTRL  = 7'h63;
	localparam logic [6:0] KEY_LMETA = 7'h66;
	localparam logic [6:0] KEY_RMETA = 7'h67;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd20;
	localparam logic [23:0] ACK_TIMEOUT_RESET = 24'd143000;
	localparam logic [15:0] GAP_RESET         = 16'd200;

	typedef enum logic [1:0] {
		REG_HALF_PERIOD = 2'd0,
		REG_ACK_TIMEOUT = 2'd1,
		REG_GAP         = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_WAIT_CLK    = 3'd0,
		PH_SETUP       = 3'd1,
		PH_LOW         = 3'd2,
		PH_ACK_WAIT    = 3'd3,
		PH_ACK_RELEASE = 3'd4,
		PH_GAP         = 3'd5,
		PH_IDLE        = 3'd6
	} phase_t;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [23:0] ack_timeout_ticks;
		logic [15:0] gap_ticks;
	} cfg_t;

	// One classified input item as it travels from the front to the back.
	typedef struct packed {
		logic       is_event;
		logic       key_pressed;
		logic [2:0] combo_mask;
		logic [7:0] key_byte;
		logic       data_hi;
		logic       clk_hi;
	} item_t;

	typedef struct packed {
		logic       clock_drive_low;
		logic       data_drive_low;
		logic       busy_res;
		logic       event_accepted;
		logic       byte_finished;
		logic       ack_timed_out;
		logic [7:0] last_byte;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/kbd_tx_if.sv =====
// Channel interfaces of the keyboard serial key transmitter.
`default_nettype none
interface kbd_tx_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [6:0] keycode;
	logic       key_pressed;
	logic       data_line_high;
	logic       clock_line_high;
	modport source(output valid, command, keycode, key_pressed, data_line_high,
		clock_line_high, input ready);
	modport sink(input valid, command, keycode, key_pressed, data_line_high,
		clock_line_high, output ready);
endinterface

interface kbd_tx_out_if;
	logic       valid;
	logic       ready;
	logic       clock_drive_low;
	logic       data_drive_low;
	logic       busy_res;
	logic       event_accepted;
	logic       byte_finished;
	logic       ack_timed_out;
	logic [7:0] last_byte;
	modport source(output valid, clock_drive_low, data_drive_low, busy_res,
		event_accepted, byte_finished, ack_timed_out, last_byte, input ready);
	modport sink(input valid, clock_drive_low, data_drive_low, busy_res,
		event_accepted, byte_finished, ack_timed_out, last_byte, output ready);
endinterface

interface kbd_tx_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/kbd_tx_front.sv =====
// Front end: accepts input transactions and classifies them into queue items.
`default_nettype none
module kbd_tx_front
	import kbd_tx_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	kbd_tx_in_if.sink  in_ch,
	output item_t      push_item,
	output logic       push_valid,
	input  wire logic  push_ready
);

	item_t item_c;
	item_t item_s1;
	logic  valid_s1;

	// Item fields and combo mask bit of the three keys of the warning code.
	always_comb begin
		item_c.is_event    = in_ch.command;
		item_c.key_pressed = in_ch.key_pressed;
		item_c.key_byte    = {in_ch.keycode, ~in_ch.key_pressed};
		item_c.data_hi     = in_ch.data_line_high;
		item_c.clk_hi      = in_ch.clock_line_high;
		unique case (in_ch.keycode)
			KEY_CTRL:  item_c.combo_mask = 3'b001;
			KEY_LMETA: item_c.combo_mask = 3'b010;
			KEY_RMETA: item_c.combo_mask = 3'b100;
			default:   item_c.combo_mask = 3'b000;
		endcase
	end

	assign in_ch.ready = !valid_s1 || push_ready;
	assign push_valid  = valid_s1;
	assign push_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbd_tx_queue.sv =====
// Small first-in first-out queue between the front and the back.
`default_nettype none
module kbd_tx_queue
	import kbd_tx_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t push_item,
	input  wire logic  push_valid,
	output logic       push_ready,
	output item_t      pop_item,
	output logic       pop_valid,
	input  wire logic  pop_ready
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	item_t         entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbd_tx_back.sv =====
// Back end: line sequencer, combo tracking and the result register.
`default_nettype none
module kbd_tx_back
	import kbd_tx_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t pop_item,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	output res_t       res,
	output logic       res_valid,
	input  wire logic  res_ready
);

	phase_t      phase_q, phase_n;
	logic [7:0]  shift_q, shift_n;
	logic [3:0]  bits_q, bits_n;
	logic [23:0] timer_q, timer_n;
	logic [2:0]  combo_q, combo_n;
	logic        warn_q, warn_n;
	logic        sync_q, sync_n;
	res_t        res_q, res_n;
	logic        res_valid_q;

	logic [23:0] timer_inc;
	logic        half_hit;
	logic        end_byte;
	logic        gap_done;
	logic [2:0]  bit_sel;

	assign pop_ready = !res_valid_q || res_ready;
	assign timer_inc = timer_q + 24'd1;
	assign half_hit  = timer_inc >= {8'd0, cfg.half_period_ticks};

	// Next state.
	always_comb begin
		phase_n  = phase_q;
		shift_n  = shift_q;
		bits_n   = bits_q;
		timer_n  = timer_q;
		combo_n  = combo_q;
		warn_n   = warn_q;
		sync_n   = sync_q;
		end_byte = 1'b0;
		gap_done = 1'b0;
		res_n    = '0;
		if (pop_item.is_event) begin
			if (phase_q == PH_IDLE) begin
				combo_n = pop_item.key_pressed ? (combo_q | pop_item.combo_mask)
					: (combo_q & ~pop_item.combo_mask);
				bits_n  = 4'd8;
				timer_n = '0;
				phase_n = PH_SETUP;
				if (combo_n == 3'b111) begin
					warn_n  = 1'b1;
					shift_n = {WARN_CODE, 1'b0};
				end else begin
					shift_n = pop_item.key_byte;
				end
				res_n.event_accepted = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_WAIT_CLK: begin
					if (pop_item.clk_hi) begin
						sync_n  = 1'b1;
						shift_n = SYNC_BYTE;
						bits_n  = 4'd8;
						timer_n = '0;
						phase_n = PH_SETUP;
					end
				end
				PH_SETUP: begin
					timer_n = timer_inc;
					if (half_hit) begin
						timer_n = '0;
						phase_n = PH_LOW;
					end
				end
				PH_LOW: begin
					timer_n = timer_inc;
					if (half_hit) begin
						timer_n = '0;
						if (bits_q > 4'd1) begin
							bits_n  = bits_q - 4'd1;
							phase_n = PH_SETUP;
						end else begin
							bits_n  = '0;
							phase_n = PH_ACK_WAIT;
						end
					end
				end
				PH_ACK_WAIT: begin
					if (!pop_item.data_hi) begin
						timer_n = '0;
						phase_n = PH_ACK_RELEASE;
					end else begin
						timer_n = timer_inc;
						if (timer_inc >= cfg.ack_timeout_ticks) begin
							timer_n             = '0;
							end_byte            = 1'b1;
							res_n.ack_timed_out = 1'b1;
						end
					end
				end
				PH_ACK_RELEASE: begin
					if (pop_item.data_hi) begin
						end_byte = 1'b1;
					end
				end
				PH_GAP: begin
					timer_n = timer_inc;
					if (timer_inc >= {8'd0, cfg.gap_ticks}) begin
						timer_n  = '0;
						gap_done = 1'b1;
					end
				end
				PH_IDLE: begin
				end
				default: begin
				end
			endcase
		end

		// A finished byte either closes the sync phase or opens the gap.
		if (end_byte) begin
			res_n.byte_finished = 1'b1;
			res_n.last_byte     = shift_q;
			if (sync_q) begin
				sync_n  = 1'b0;
				phase_n = PH_IDLE;
			end else begin
				timer_n = '0;
				phase_n = PH_GAP;
				if (cfg.gap_ticks == '0) begin
					gap_done = 1'b1;
				end
			end
		end

		// After the gap the pending warning release goes out, if any.
		if (gap_done) begin
			if (warn_q) begin
				warn_n  = 1'b0;
				shift_n = {WARN_CODE, 1'b1};
				bits_n  = 4'd8;
				timer_n = '0;
				phase_n = PH_SETUP;
			end else begin
				phase_n = PH_IDLE;
			end
		end
	end

	// Line outputs follow the state after this item.
	assign bit_sel = 3'(bits_n - 4'd1);

	res_t res_full;
	always_comb begin
		res_full                 = res_n;
		res_full.clock_drive_low = (phase_n == PH_LOW);
		res_full.data_drive_low  = ((phase_n == PH_SETUP) || (phase_n == PH_LOW))
			&& (bits_n != 4'd0) && (bits_n <= 4'd8) && shift_n[bit_sel];
		res_full.busy_res        = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_CLK;
			shift_q     <= SYNC_BYTE;
			bits_q      <= 4'd8;
			timer_q     <= '0;
			combo_q     <= '0;
			warn_q      <= 1'b0;
			sync_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else if (pop_ready) begin
			res_valid_q <= pop_valid;
			if (pop_valid) begin
				phase_q <= phase_n;
				shift_q <= shift_n;
				bits_q  <= bits_n;
				timer_q <= timer_n;
				combo_q <= combo_n;
				warn_q  <= warn_n;
				sync_q  <= sync_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			res_q <= res_full;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	a_timeout_with_finish: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.ack_timed_out |-> res_q.byte_finished)
		else $error("timeout reported without a finished byte");

	a_byte_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.byte_finished |-> res_q.last_byte == 8'd0)
		else $error("last byte set without a finished byte");

	a_clock_low_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.clock_drive_low |-> res_q.busy_res)
		else $error("clock driven low while idle");

	a_idle_after_sync: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !sync_q)
		else $error("idle while the sync byte is still flagged");

	a_busy_event_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready && pop_valid && pop_item.is_event && phase_q != PH_IDLE
		|=> res_valid_q && !res_q.event_accepted && $stable(combo_q))
		else $error("event taken while busy");

endmodule
`default_nettype wire

// ===== rtl/keyboard_serial_key_transmitter.sv =====
// Top level of the keyboard serial key transmitter.
// The block drives a two-wire open-drain keyboard link (clock and data,
// pulled high outside) from a stream of input transactions. A transaction
// is either a time tick carrying the sampled line levels or a key event.
// Every accepted transaction produces exactly one result transaction that
// carries the line drive levels after that transaction, the busy flag, and
// pulses for an accepted event and for a finished byte. One transaction is
// accepted per clock cycle while the queue has room; a transaction's result
// passes through the classifying front stage register, a queue entry and
// the result register loaded by the line sequencer, in that order. The line
// sequencer handles one transaction per cycle, so the sustained rate is set
// by that single back-end step and by how fast the result channel is
// drained. The queue between the front and the back holds QUEUE_DEPTH
// transactions, so each side can stall on its own. After reset the block
// waits for a tick that sees the clock line high and then sends the sync
// byte 0xFF; key events are accepted (event_accepted set) only while the
// block is idle and are dropped otherwise. Bytes go out MSB first, with a 1
// bit pulling data low. Holding control together with both meta keys sends
// the warning code 0x78 down and then up instead of the key. Timing
// registers (written on the configuration channel, by the user only while
// idle, which the block itself does not enforce): index 0 is the half period
// in ticks, index 1 the acknowledge timeout in ticks, index 2 the idle gap
// after each key byte in ticks. Index 3 is ignored. The configuration
// channel is always ready.
`default_nettype none
module keyboard_serial_key_transmitter
	import kbd_tx_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	kbd_tx_in_if.sink   key_in,
	kbd_tx_out_if.source res_out,
	kbd_tx_cfg_if.sink  cfg
);

	cfg_t  cfg_q;
	item_t push_item;
	logic  push_valid;
	logic  push_ready;
	item_t pop_item;
	logic  pop_valid;
	logic  pop_ready;
	res_t  res;

	// Configuration writes land in the timing registers at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RESET;
			cfg_q.ack_timeout_ticks <= ACK_TIMEOUT_RESET;
			cfg_q.gap_ticks         <= GAP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg.data[15:0];
				REG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg.data;
				REG_GAP:         cfg_q.gap_ticks         <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	kbd_tx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (key_in),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	kbd_tx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	kbd_tx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.res       (res),
		.res_valid (res_out.valid),
		.res_ready (res_out.ready)
	);

	assign res_out.clock_drive_low = res.clock_drive_low;
	assign res_out.data_drive_low  = res.data_drive_low;
	assign res_out.busy_res        = res.busy_res;
	assign res_out.event_accepted  = res.event_accepted;
	assign res_out.byte_finished   = res.byte_finished;
	assign res_out.ack_timed_out   = res.ack_timed_out;
	assign res_out.last_byte       = res.last_byte;

endmodule
`default_nettype wire

// ===== test/keyboard_serial_key_transmitter_tb.sv =====
// Self-checking testbench for the keyboard serial key transmitter.
`timescale 1ns / 100ps
module keyboard_serial_key_transmitter_tb;
	import kbd_tx_pkg::*;

	// A tick transaction advances the line sequencer by one time step and
	// carries the sampled line levels. A key transaction offers a key event.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	// Index 3 decodes to no register. Writing it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Cycles without any accepted transaction before the run is declared hung.
	// The longest legal quiet stretch is a drain plus a register write, or a
	// run of receiver stalls at 84 percent, both far below this.
	localparam int unsigned QUIET_LIMIT = 3000;

	// Cycles to let pass after the last result.
	localparam int unsigned TAIL_CYCLES = 10;

	// One input transaction as the testbench builds it.
	typedef struct {
		logic       command;
		logic [6:0] keycode;
		logic       key_pressed;
		logic       data_hi;
		logic       clk_hi;
	} key_xact_t;

	// State of the link sequencer as the testbench tracks it.
	typedef struct {
		phase_t      phase;
		logic [7:0]  shift;
		logic [3:0]  bits_left;
		logic [23:0] timer;
		logic [2:0]  held;
		logic        warn_pending;
		logic        sync;
	} link_t;

	logic clk = 1'b0;
	logic arst_n;

	kbd_tx_in_if  key_in();
	kbd_tx_out_if res_out();
	kbd_tx_cfg_if cfg();

	keyboard_serial_key_transmitter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_in),
		.res_out (res_out),
		.cfg     (cfg)
	);

	// 20 ns period, starting low.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Timing registers as the block should hold them. They change only while
	// nothing is in flight, so the stimulus builder and the checker share them.
	cfg_t link_cfg;

	// The stimulus builder keeps its own copy of the link state so that it can
	// answer the sequencer the way a real host would (acknowledge at the right
	// time, offer keys while idle). The checker's copy advances only when the
	// block accepts a transaction.
	link_t build_link;
	link_t check_link;

	key_xact_t key_traffic[$];
	res_t      expected_line_res[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	function automatic link_t link_after_reset();
		link_t s;
		s.phase        = PH_WAIT_CLK;
		s.shift        = SYNC_BYTE;
		s.bits_left    = 4'd8;
		s.timer        = '0;
		s.held         = '0;
		s.warn_pending = 1'b0;
		s.sync         = 1'b1;
		return s;
	endfunction

	function automatic void load_byte(inout link_t s, input logic [7:0] value);
		s.shift     = value;
		s.bits_left = 4'd8;
		s.timer     = '0;
		s.phase     = PH_SETUP;
	endfunction

	// At the end of a gap the second half of the warning sequence goes out,
	// if one is owed.
	function automatic void gap_over(inout link_t s);
		if (s.warn_pending) begin
			s.warn_pending = 1'b0;
			load_byte(s, {WARN_CODE, 1'b1});
		end else begin
			s.phase = PH_IDLE;
		end
	endfunction

	// The sync byte returns straight to idle; key bytes are followed by a gap.
	function automatic void byte_over(inout link_t s);
		if (s.sync) begin
			s.sync  = 1'b0;
			s.phase = PH_IDLE;
		end else begin
			s.timer = '0;
			s.phase = PH_GAP;
			if (link_cfg.gap_ticks == '0)
				gap_over(s);
		end
	endfunction

	// Advances the link by one transaction and returns the result it produces.
	function automatic res_t advance_link(inout link_t s, input key_xact_t x);
		res_t       r;
		logic [2:0] mask;
		logic       bit_now;
		r    = '0;
		mask = '0;
		if (x.command == CMD_KEY) begin
			// Events are only taken while idle; otherwise they leave no trace.
			if (s.phase == PH_IDLE) begin
				case (x.keycode)
					KEY_CTRL:  mask = 3'b001;
					KEY_LMETA: mask = 3'b010;
					KEY_RMETA: mask = 3'b100;
					default:   mask = 3'b000;
				endcase
				if (x.key_pressed)
					s.held = s.held | mask;
				else
					s.held = s.held & ~mask;
				if (s.held == 3'b111) begin
					s.warn_pending = 1'b1;
					load_byte(s, {WARN_CODE, 1'b0});
				end else begin
					load_byte(s, {x.keycode, ~x.key_pressed});
				end
				r.event_accepted = 1'b1;
			end
		end else begin
			case (s.phase)
				PH_WAIT_CLK: begin
					if (x.clk_hi) begin
						s.sync = 1'b1;
						load_byte(s, SYNC_BYTE);
					end
				end
				PH_SETUP: begin
					s.timer = s.timer + 24'd1;
					if (s.timer >= link_cfg.half_period_ticks) begin
						s.timer = '0;
						s.phase = PH_LOW;
					end
				end
				PH_LOW: begin
					s.timer = s.timer + 24'd1;
					if (s.timer >= link_cfg.half_period_ticks) begin
						s.timer = '0;
						if (s.bits_left > 4'd1) begin
							s.bits_left = s.bits_left - 4'd1;
							s.phase     = PH_SETUP;
						end else begin
							s.bits_left = '0;
							s.phase     = PH_ACK_WAIT;
						end
					end
				end
				PH_ACK_WAIT: begin
					if (!x.data_hi) begin
						s.timer = '0;
						s.phase = PH_ACK_RELEASE;
					end else begin
						s.timer = s.timer + 24'd1;
						if (s.timer >= link_cfg.ack_timeout_ticks) begin
							s.timer         = '0;
							r.byte_finished = 1'b1;
							r.ack_timed_out = 1'b1;
							r.last_byte     = s.shift;
							byte_over(s);
						end
					end
				end
				PH_ACK_RELEASE: begin
					if (x.data_hi) begin
						r.byte_finished = 1'b1;
						r.last_byte     = s.shift;
						byte_over(s);
					end
				end
				PH_GAP: begin
					s.timer = s.timer + 24'd1;
					if (s.timer >= link_cfg.gap_ticks) begin
						s.timer = '0;
						gap_over(s);
					end
				end
				default: ;
			endcase
		end
		// The link is active low: a 1 bit pulls data down while it is on the wire.
		if (s.bits_left >= 4'd1 && s.bits_left <= 4'd8)
			bit_now = s.shift[s.bits_left - 4'd1];
		else
			bit_now = 1'b0;
		r.clock_drive_low = (s.phase == PH_LOW);
		r.data_drive_low  = (s.phase == PH_SETUP || s.phase == PH_LOW) && bit_now;
		r.busy_res        = (s.phase != PH_IDLE);
		return r;
	endfunction

	// Input driver. A transaction stays on the channel until it is taken; a new
	// one is offered only after that, possibly after random idle cycles.
	always @(posedge clk or negedge arst_n) begin : key_driver
		logic took;
		if (!arst_n) begin
			key_in.valid           <= 1'b0;
			key_in.command         <= CMD_TICK;
			key_in.keycode         <= '0;
			key_in.key_pressed     <= 1'b0;
			key_in.data_line_high  <= 1'b1;
			key_in.clock_line_high <= 1'b1;
		end else begin
			took = key_in.valid && key_in.ready;
			if (took)
				expected_line_res.push_back(advance_link(check_link, key_traffic.pop_front()));
			if (!key_in.valid || took) begin
				if (key_traffic.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					key_in.valid           <= 1'b1;
					key_in.command         <= key_traffic[0].command;
					key_in.keycode         <= key_traffic[0].keycode;
					key_in.key_pressed     <= key_traffic[0].key_pressed;
					key_in.data_line_high  <= key_traffic[0].data_hi;
					key_in.clock_line_high <= key_traffic[0].clk_hi;
				end else begin
					key_in.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result monitor. Every result transaction is matched against the oldest
	// expectation, one field at a time.
	always @(posedge clk or negedge arst_n) begin : res_monitor
		res_t got;
		res_t want;
		if (!arst_n) begin
			res_out.ready <= 1'b0;
		end else begin
			if (res_out.valid && res_out.ready) begin
				got.clock_drive_low = res_out.clock_drive_low;
				got.data_drive_low  = res_out.data_drive_low;
				got.busy_res        = res_out.busy_res;
				got.event_accepted  = res_out.event_accepted;
				got.byte_finished   = res_out.byte_finished;
				got.ack_timed_out   = res_out.ack_timed_out;
				got.last_byte       = res_out.last_byte;
				if (expected_line_res.size() == 0) begin
					$display("%0t ns: result expected none actual %p", $time, got);
					mismatch_count++;
				end else begin
					want = expected_line_res.pop_front();
					check_field("clock_drive_low", want.clock_drive_low, got.clock_drive_low);
					check_field("data_drive_low", want.data_drive_low, got.data_drive_low);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("event_accepted", want.event_accepted, got.event_accepted);
					check_field("byte_finished", want.byte_finished, got.byte_finished);
					check_field("ack_timed_out", want.ack_timed_out, got.ack_timed_out);
					check_field("last_byte", want.last_byte, got.last_byte);
				end
			end
			res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Hang detection: any transaction on any channel resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((key_in.valid && key_in.ready) || (res_out.valid && res_out.ready)
				|| (cfg.valid && cfg.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_xact(input key_xact_t x);
		void'(advance_link(build_link, x));
		key_traffic.push_back(x);
	endtask

	// Ticks also carry random key fields, which the block must ignore.
	task automatic queue_tick(input logic data_hi, input logic clk_hi);
		key_xact_t x;
		x.command     = CMD_TICK;
		x.keycode     = $urandom_range(127);
		x.key_pressed = $urandom_range(1);
		x.data_hi     = data_hi;
		x.clk_hi      = clk_hi;
		queue_xact(x);
	endtask

	task automatic queue_key(input logic [6:0] code, input logic down);
		key_xact_t x;
		x.command     = CMD_KEY;
		x.keycode     = code;
		x.key_pressed = down;
		x.data_hi     = $urandom_range(1);
		x.clk_hi      = $urandom_range(1);
		queue_xact(x);
	endtask

	// Clocks the current byte out until the sequencer looks for an acknowledge.
	task automatic queue_to_ack_wait();
		while (build_link.phase != PH_ACK_WAIT)
			queue_tick(1'b1, $urandom_range(1));
	endtask

	// Host acknowledge: data pulled low for two samples, then released.
	task automatic queue_ack();
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b1);
	endtask

	// Runs the link to idle, acknowledging every byte on the way.
	task automatic queue_settle();
		while (build_link.phase != PH_IDLE)
			queue_tick(build_link.phase != PH_ACK_WAIT, 1'b1);
	endtask

	// Random traffic shaped by what the link is doing: keys while idle, ticks
	// otherwise, acknowledges that sometimes come too late, and a sprinkling of
	// keys during a transfer that the block must reject. Transactions that the
	// block only ignores are not counted.
	task automatic queue_random(input int unsigned count);
		key_xact_t   x;
		int unsigned counted;
		counted = 0;
		while (counted < count) begin
			x.command     = CMD_TICK;
			x.keycode     = $urandom_range(127);
			x.key_pressed = $urandom_range(1);
			x.data_hi     = $urandom_range(1);
			x.clk_hi      = $urandom_range(1);
			case (build_link.phase)
				PH_IDLE: begin
					if ($urandom_range(4) != 0) begin
						x.command = CMD_KEY;
						// Lean on the three modifier keys so the warning sequence comes up.
						if ($urandom_range(4) < 2) begin
							case ($urandom_range(2))
								0:       x.keycode = KEY_CTRL;
								1:       x.keycode = KEY_LMETA;
								default: x.keycode = KEY_RMETA;
							endcase
						end
					end
				end
				PH_WAIT_CLK: ;
				PH_ACK_WAIT: x.data_hi = ($urandom_range(2) != 0);
				PH_ACK_RELEASE: ;
				default: begin
					if ($urandom_range(9) == 0)
						x.command = CMD_KEY;
				end
			endcase
			if ((x.command == CMD_KEY) == (build_link.phase == PH_IDLE))
				counted++;
			queue_xact(x);
		end
	endtask

	// Waits until every queued transaction has been taken and answered.
	task automatic drain();
		while (key_traffic.size() != 0 || expected_line_res.size() != 0 || key_in.valid)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_HALF_PERIOD: link_cfg.half_period_ticks = value[15:0];
			REG_ACK_TIMEOUT: link_cfg.ack_timeout_ticks = value;
			REG_GAP:         link_cfg.gap_ticks = value[15:0];
			default: ;
		endcase
	endtask

	// Upper bits of the 16-bit registers are filled with junk the block drops.
	task automatic set_timing(input logic [15:0] half_period, input logic [23:0] timeout,
		input logic [15:0] gap);
		write_reg(REG_HALF_PERIOD, {8'($urandom), half_period});
		write_reg(REG_ACK_TIMEOUT, timeout);
		write_reg(REG_GAP, {8'($urandom), gap});
	endtask

	task automatic random_phase(input logic [15:0] half_period, input logic [23:0] timeout,
		input logic [15:0] gap, input int unsigned send_idle, input int unsigned recv_stall);
		drain();
		set_timing(half_period, timeout, gap);
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		queue_random(65);
	endtask

	initial begin
		// Every block input is known from time zero.
		arst_n                 = 1'b0;
		key_in.valid           = 1'b0;
		key_in.command         = CMD_TICK;
		key_in.keycode         = '0;
		key_in.key_pressed     = 1'b0;
		key_in.data_line_high  = 1'b1;
		key_in.clock_line_high = 1'b1;
		res_out.ready          = 1'b0;
		cfg.valid              = 1'b0;
		cfg.index              = REG_HALF_PERIOD;
		cfg.data               = '0;
		send_idle_pct          = 0;
		recv_stall_pct         = 0;
		mismatch_count         = 0;
		quiet_cycles           = 0;
		link_cfg.half_period_ticks = HALF_PERIOD_RESET;
		link_cfg.ack_timeout_ticks = ACK_TIMEOUT_RESET;
		link_cfg.gap_ticks         = GAP_RESET;
		build_link = link_after_reset();
		check_link = link_after_reset();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset timing: the block waits for the clock line, refuses a
		// key while it waits, then starts the sync byte. Twenty-two ticks cover
		// the full 20-tick setup of the first bit and the start of its low phase.
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		queue_key(7'h7F, 1'b1);
		queue_tick(1'b1, 1'b1);
		repeat (22)
			queue_tick($urandom_range(1), $urandom_range(1));
		drain();

		// Fast timing, no gap. The sync byte times out without an acknowledge,
		// then a tick while idle does nothing.
		set_timing(16'd1, 24'd2, 16'd0);
		queue_to_ack_wait();
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b1);

		// Lowest key code pressed; a key during the transfer is dropped; data is
		// held low for a while after the acknowledge before it is released.
		queue_key(7'h00, 1'b1);
		queue_key(7'h12, 1'b0);
		queue_to_ack_wait();
		queue_tick(1'b0, 1'b1);
		repeat (6)
			queue_tick(1'b0, $urandom_range(1));
		queue_tick(1'b1, 1'b0);

		// Highest key code released, acknowledged normally.
		queue_key(7'h7F, 1'b0);
		queue_to_ack_wait();
		queue_ack();

		// Control and both meta keys held: the third press turns into the
		// warning code down and up, back to back since there is no gap.
		queue_key(KEY_CTRL, 1'b1);
		queue_settle();
		queue_key(KEY_LMETA, 1'b1);
		queue_settle();
		queue_key(KEY_RMETA, 1'b1);
		queue_settle();
		queue_key(KEY_LMETA, 1'b0);
		queue_settle();
		drain();

		// Largest timeout and gap: a slow acknowledge must not time out, and the
		// gap is left part way through.
		set_timing(16'd1, 24'hFF_FFFF, 16'hFFFF);
		queue_key($urandom_range(127), $urandom_range(1));
		queue_to_ack_wait();
		repeat (30)
			queue_tick(1'b1, $urandom_range(1));
		queue_ack();
		repeat (30)
			queue_tick($urandom_range(1), $urandom_range(1));
		drain();

		// Dropping the gap to zero ends it on the next tick. Then the largest
		// half period holds the first bit in setup.
		set_timing(16'hFFFF, 24'd4, 16'd0);
		queue_tick(1'b1, 1'b1);
		queue_key($urandom_range(127), $urandom_range(1));
		repeat (30)
			queue_tick($urandom_range(1), $urandom_range(1));

		// Random traffic over several timings and handshake pressures. Zero half
		// period and zero timeout come first; they act as one tick.
		random_phase(16'd0, 24'd0, 16'd1, 0, 0);
		random_phase(16'd1, 24'd3, 16'd0, 84, 0);
		random_phase(16'd2, 24'd5, 16'd2, 0, 84);
		random_phase(16'd1, 24'd2, 16'd1, 6, 6);
		drain();
		write_reg(REG_SPARE, 24'hFF_FFFF);
		random_phase(16'd1, 24'd4, 16'd0, 0, 0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_line_res.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, expected_line_res.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/kbd_tx_pkg.sv
rtl/kbd_tx_if.sv
rtl/kbd_tx_front.sv
rtl/kbd_tx_queue.sv
rtl/kbd_tx_back.sv
rtl/keyboard_serial_key_transmitter.sv
test/keyboard_serial_key_transmitter_tb.sv
